// File: rtl/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg: shared types and constants for the Q1.15 FIR filter
// Data widths, function codes, rounding/saturation constants and the
// control bundle that travels alongside the tap reads.
// ----------------------------------------------------------------------------
package fir_pkg;

  // default number of taps
  localparam int TAPS_DEFAULT = 64;

  // field widths
  localparam int DATA_W      = 16;
  localparam int PROD_W      = 32;
  localparam int ACC_W       = 40;
  localparam int TAP_CNT_W   = 7;
  localparam int COEF_IDX_W  = 6;

  // function codes of an input item
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  // tap_count after reset
  localparam logic [TAP_CNT_W-1:0] TAP_CNT_RESET = 7'd64;

  // round half up before the shift by 15
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 40'sd16384;

  // saturation limits
  localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

  // control bundle for one tap read
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

// File: rtl/fir_filter_q15.sv
// ----------------------------------------------------------------------------
// fir_filter_q15: direct-form Q1.15 FIR filter
//
//   channel  signals                                    direction
//   in       in_valid/in_stall, func, sample,           into block
//            coef_index, coef_value
//   out      out_valid/out_stall, filtered, saturated   out of block
//   cfg      cfg_we, cfg_data (tap_count)               into block
//
// After a sample transfer no new item is accepted until its result has left
// the MAC: one shared multiply-accumulate walks n taps, n being tap_count held
// to 1..TAPS, one memory read per tap. A coefficient write does not stall the
// input. After reset a clearing pass zeroes both memories while in_stall is
// high. A result waiting on out_stall holds in the output register; a second
// one holds in the MAC.
// ----------------------------------------------------------------------------
module fir_filter_q15 #(
  parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  func,
  input  logic signed [fir_pkg::DATA_W-1:0]     sample,
  input  logic [fir_pkg::COEF_IDX_W-1:0]        coef_index,
  input  logic signed [fir_pkg::DATA_W-1:0]     coef_value,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fir_pkg::DATA_W-1:0]     filtered,
  output logic                                  saturated,
  // configuration
  input  logic                                  cfg_we,
  input  logic [fir_pkg::TAP_CNT_W-1:0]         cfg_data
);

  localparam int AW = $clog2(TAPS);
  localparam int CW = $clog2(TAPS + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  state_t                            state;
  logic [AW-1:0]                     clr_cnt;
  logic [AW-1:0]                     ptr;
  logic [AW-1:0]                     rd_ptr;
  logic [CW-1:0]                     tap_idx;
  logic [CW-1:0]                     tap_lim;
  logic [fir_pkg::TAP_CNT_W-1:0]     tap_count;

  logic                              in_xfer;
  logic                              coef_ok;
  logic [AW-1:0]                     ptr_adv;
  logic [CW-1:0]                     tap_lim_next;
  logic [CW+6:0]                     tc_wide;

  logic                              coef_we;
  logic [AW-1:0]                     coef_waddr;
  logic signed [fir_pkg::DATA_W-1:0] coef_wdata;
  logic                              smp_we;
  logic [AW-1:0]                     smp_waddr;
  logic signed [fir_pkg::DATA_W-1:0] smp_wdata;
  fir_pkg::mac_ctl_t                 rd_ctl;
  fir_pkg::mac_ctl_t                 rd_ctl_q;
  logic signed [fir_pkg::DATA_W-1:0] coef_rdata;
  logic signed [fir_pkg::DATA_W-1:0] smp_rdata;

  logic                              res_valid;
  logic                              res_take;
  logic signed [fir_pkg::DATA_W-1:0] res_filtered;
  logic                              res_sat;

  // input transfer
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign coef_ok  = (32'(coef_index) < TAPS);
  assign ptr_adv  = (ptr == AW'(TAPS - 1)) ? '0 : ptr + AW'(1);

  // effective tap count: 0 acts as 1, above TAPS acts as TAPS
  assign tc_wide = (CW + 7)'(tap_count);
  always_comb begin
    if (tap_count == '0) begin
      tap_lim_next = CW'(1);
    end else if (tc_wide > (CW + 7)'(TAPS)) begin
      tap_lim_next = CW'(TAPS);
    end else begin
      tap_lim_next = CW'(tap_count);
    end
  end

  // memory writes: clearing pass, coefficient item, new sample
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = clr_cnt;
    coef_wdata = '0;
    smp_we     = 1'b0;
    smp_waddr  = clr_cnt;
    smp_wdata  = '0;
    if (state == S_CLEAR) begin
      coef_we = 1'b1;
      smp_we  = 1'b1;
    end else if (in_xfer) begin
      if (func == fir_pkg::FUNC_COEF) begin
        coef_we    = coef_ok;
        coef_waddr = AW'(coef_index);
        coef_wdata = coef_value;
      end else begin
        smp_we    = 1'b1;
        smp_waddr = ptr_adv;
        smp_wdata = sample;
      end
    end
  end

  // tap read issue
  always_comb begin
    rd_ctl.valid = (state == S_RUN);
    rd_ctl.first = (tap_idx == '0);
    rd_ctl.last  = (tap_idx == tap_lim - CW'(1));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      ptr     <= '0;
      rd_ptr  <= '0;
      tap_idx <= '0;
      tap_lim <= CW'(1);
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(TAPS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer && func == fir_pkg::FUNC_SAMPLE) begin
            ptr     <= ptr_adv;
            rd_ptr  <= ptr_adv;
            tap_idx <= '0;
            tap_lim <= tap_lim_next;
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          tap_idx <= tap_idx + CW'(1);
          rd_ptr  <= (rd_ptr == '0) ? AW'(TAPS - 1) : rd_ptr - AW'(1);
          if (rd_ctl.last) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= fir_pkg::TAP_CNT_RESET;
    end else if (cfg_we) begin
      tap_count <= cfg_data;
    end
  end

  // output register
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      filtered  <= res_filtered;
      saturated <= res_sat;
    end
  end

  fir_store #(
    .TAPS (TAPS),
    .AW   (AW)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .smp_we     (smp_we),
    .smp_waddr  (smp_waddr),
    .smp_wdata  (smp_wdata),
    .rd_ctl     (rd_ctl),
    .coef_raddr (tap_idx[AW-1:0]),
    .smp_raddr  (rd_ptr),
    .rd_ctl_q   (rd_ctl_q),
    .coef_rdata (coef_rdata),
    .smp_rdata  (smp_rdata)
  );

  fir_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .in_ctl       (rd_ctl_q),
    .coef         (coef_rdata),
    .smp          (smp_rdata),
    .res_take     (res_take),
    .res_valid    (res_valid),
    .res_filtered (res_filtered),
    .res_sat      (res_sat)
  );

endmodule

// File: rtl/fir_store.sv
// ----------------------------------------------------------------------------
// fir_store: coefficient and sample memories
// Two single-write, single-read synchronous memories of TAPS entries with a
// registered read; the tap control bundle is delayed to line up with the data.
// ----------------------------------------------------------------------------
module fir_store #(
  parameter int TAPS = fir_pkg::TAPS_DEFAULT,
  parameter int AW   = $clog2(TAPS)
) (
  input  logic                              clk,
  input  logic                              rst,
  // coefficient write port
  input  logic                              coef_we,
  input  logic [AW-1:0]                     coef_waddr,
  input  logic signed [fir_pkg::DATA_W-1:0] coef_wdata,
  // sample write port
  input  logic                              smp_we,
  input  logic [AW-1:0]                     smp_waddr,
  input  logic signed [fir_pkg::DATA_W-1:0] smp_wdata,
  // tap read
  input  fir_pkg::mac_ctl_t                 rd_ctl,
  input  logic [AW-1:0]                     coef_raddr,
  input  logic [AW-1:0]                     smp_raddr,
  output fir_pkg::mac_ctl_t                 rd_ctl_q,
  output logic signed [fir_pkg::DATA_W-1:0] coef_rdata,
  output logic signed [fir_pkg::DATA_W-1:0] smp_rdata
);

  logic signed [fir_pkg::DATA_W-1:0] coef_mem [TAPS];
  logic signed [fir_pkg::DATA_W-1:0] smp_mem  [TAPS];

  // coefficient memory
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    if (rd_ctl.valid) begin
      coef_rdata <= coef_mem[coef_raddr];
    end
  end

  // sample memory (circular history)
  always_ff @(posedge clk) begin
    if (smp_we) begin
      smp_mem[smp_waddr] <= smp_wdata;
    end
    if (rd_ctl.valid) begin
      smp_rdata <= smp_mem[smp_raddr];
    end
  end

  // control follows the read latency
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl_q <= '0;
    end else begin
      rd_ctl_q <= rd_ctl;
    end
  end

endmodule

// File: rtl/fir_mac.sv
// ----------------------------------------------------------------------------
// fir_mac: multiply-accumulate and output scaling
// Registered 16x16 product, 40-bit accumulator, then round, shift by 15 and
// saturate into a result register held until the top level takes it.
// ----------------------------------------------------------------------------
module fir_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  fir_pkg::mac_ctl_t                 in_ctl,
  input  logic signed [fir_pkg::DATA_W-1:0] coef,
  input  logic signed [fir_pkg::DATA_W-1:0] smp,
  input  logic                              res_take,
  output logic                              res_valid,
  output logic signed [fir_pkg::DATA_W-1:0] res_filtered,
  output logic                              res_sat
);

  fir_pkg::mac_ctl_t                prod_ctl;
  fir_pkg::mac_ctl_t                acc_ctl;
  logic signed [fir_pkg::PROD_W-1:0] prod;
  logic signed [fir_pkg::ACC_W-1:0]  acc;
  logic signed [fir_pkg::ACC_W-1:0]  prod_ext;
  logic signed [fir_pkg::ACC_W-1:0]  rsum;
  logic                              ovf;

  assign prod_ext = fir_pkg::ACC_W'(prod);
  assign rsum     = acc + fir_pkg::ROUND_BIAS;
  // shifted value fits 16 bits when bits 39..30 all agree
  assign ovf      = (rsum[fir_pkg::ACC_W-1:30] != {(fir_pkg::ACC_W-30){rsum[30]}});

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl  <= '0;
      acc_ctl   <= '0;
      res_valid <= 1'b0;
    end else begin
      prod_ctl <= in_ctl;
      acc_ctl  <= prod_ctl;
      if (acc_ctl.valid && acc_ctl.last) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  // product and accumulator
  always_ff @(posedge clk) begin
    if (in_ctl.valid) begin
      prod <= coef * smp;
    end
    if (prod_ctl.valid) begin
      acc <= prod_ctl.first ? prod_ext : acc + prod_ext;
    end
  end

  // round, shift and saturate
  always_ff @(posedge clk) begin
    if (acc_ctl.valid && acc_ctl.last) begin
      res_sat <= ovf;
      if (ovf) begin
        res_filtered <= rsum[fir_pkg::ACC_W-1] ? fir_pkg::SAT_MIN : fir_pkg::SAT_MAX;
      end else begin
        res_filtered <= rsum[30:15];
      end
    end
  end

endmodule
